/* hdl/lamp_command_frame_receiver_assert.svh */
// Assertion macros shared by the lamp command frame receiver RTL.
`ifndef LAMP_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define LAMP_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LCFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lcfr_pkg.sv */
// Types, constants and lookup tables of the lamp command frame receiver.
`default_nettype none

package lcfr_pkg;

  // Frame length in bytes, header and check byte included (4 to 15).
  localparam int FRAME_BYTES = 11;
  localparam logic [3:0] POS_LIMIT = 4'(FRAME_BYTES);
  localparam logic [3:0] POS_LAST  = 4'(FRAME_BYTES - 1);

  localparam logic [7:0] HDR0         = 8'hC8;
  localparam logic [7:0] HDR1         = 8'h8B;
  localparam logic [7:0] UNLOCK_CTRL  = 8'h06;
  localparam logic [7:0] UNLOCK_CHECK = 8'hD5;

  localparam logic [9:0] FULL_DUTY_RST = 10'(201 << 2);
  localparam logic [9:0] DIM_DUTY_RST  = 10'(81 << 2);
  localparam logic [7:0] TIMEOUT_RST   = 8'd200;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_FULL_DUTY = 2'd0;
  localparam logic [1:0] REG_DIM_DUTY  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  // Event codes of a result.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_APPLIED  = 3'd1;
  localparam logic [2:0] EV_BADCHECK = 3'd2;
  localparam logic [2:0] EV_UNLOCK   = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } lcfr_in_t;

  typedef struct packed {
    logic       high_beam;
    logic [9:0] low_beam_duty;
    logic       position_lamp;
    logic [2:0] event_res;
  } lcfr_out_t;

  typedef enum logic [1:0] {LB_OFF, LB_DIM, LB_FULL} lb_act_t;
  typedef enum logic [1:0] {PS_OFF, PS_ON, PS_KEEP} ps_act_t;

  typedef struct packed {
    logic    high;
    lb_act_t lb;
    ps_act_t ps;
  } lcfr_drive_t;

  // Expected check byte for each six-bit lamp code.
  localparam logic [7:0] CHECK_ROM [0:63] = '{
    8'h4C, 8'h9F, 8'hED, 8'h3E, 8'h66, 8'hB5, 8'hC7, 8'h14,
    8'h59, 8'h8A, 8'hF8, 8'h2B, 8'h73, 8'hA0, 8'hD2, 8'h01,
    8'h8E, 8'h5D, 8'h2F, 8'hFC, 8'hA4, 8'h77, 8'h05, 8'hD6,
    8'h9B, 8'h48, 8'h3A, 8'hE9, 8'hB1, 8'h62, 8'h10, 8'hC3,
    8'h2D, 8'hFE, 8'h8C, 8'h5F, 8'h07, 8'hD4, 8'hA6, 8'h75,
    8'h38, 8'hEB, 8'h99, 8'h4A, 8'h12, 8'hC1, 8'hB3, 8'h60,
    8'hEF, 8'h3C, 8'h4E, 8'h9D, 8'hC5, 8'h16, 8'h64, 8'hB7,
    8'hFA, 8'h29, 8'h5B, 8'h88, 8'hD0, 8'h03, 8'h71, 8'hA2
  };

  // Lamp drive selected by {HIGH, LOW, DRL, POS}.
  function automatic lcfr_drive_t drive_lookup(input logic [3:0] sel);
    lcfr_drive_t d;
    case (sel)
      4'd0:  d = '{1'b0, LB_OFF,  PS_OFF};
      4'd1:  d = '{1'b0, LB_OFF,  PS_ON};
      4'd2:  d = '{1'b0, LB_DIM,  PS_OFF};
      4'd3:  d = '{1'b0, LB_DIM,  PS_ON};
      4'd4:  d = '{1'b0, LB_FULL, PS_OFF};
      4'd5:  d = '{1'b0, LB_FULL, PS_ON};
      4'd6:  d = '{1'b0, LB_FULL, PS_OFF};
      4'd7:  d = '{1'b0, LB_FULL, PS_ON};
      4'd8:  d = '{1'b1, LB_OFF,  PS_OFF};
      4'd9:  d = '{1'b0, LB_OFF,  PS_ON};
      4'd10: d = '{1'b0, LB_DIM,  PS_KEEP};
      4'd11: d = '{1'b0, LB_DIM,  PS_ON};
      4'd12: d = '{1'b1, LB_FULL, PS_OFF};
      4'd13: d = '{1'b1, LB_FULL, PS_ON};
      4'd14: d = '{1'b1, LB_FULL, PS_OFF};
      4'd15: d = '{1'b1, LB_FULL, PS_ON};
      default: d = '{1'b0, LB_OFF, PS_OFF};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/lamp_command_frame_receiver.sv */
// Lamp command frame receiver: frame hunting, check, lamp drive and silence timeout.
//
//   Channel   Direction  Handshake                 Payload
//   in_       input      in_valid / in_ready       lcfr_in_t  (command, byte_value)
//   out_      output     out_valid / out_ready     lcfr_out_t (lamp state, event)
//   cfg       input      APB psel/penable/pwrite   full_duty, dim_duty, timeout_ticks
//
// One item per cycle is sustained while out_ready stays high: an item waits in the input
// register, the frame, check and timer logic between that register and the result
// register is combinational, and the result is then loaded into the result register.
// Reset is synchronous, active low; it skips only the item and result data registers.
// A stalled result holds the result register; the input register then still takes one
// more item before in_ready drops.
`default_nettype none

module lamp_command_frame_receiver
  import lcfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lcfr_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lcfr_out_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  logic [9:0] full_duty_r;
  logic [9:0] dim_duty_r;
  logic [7:0] timeout_r;

  logic       s1_valid_r;
  lcfr_in_t   s1_item_r;
  logic       out_valid_r;
  lcfr_out_t  out_data_r;

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] ind_r, ind_nxt;
  logic [7:0] silence_r, silence_nxt;
  logic       high_r, high_nxt;
  logic [9:0] low_r, low_nxt;
  logic       posl_r, posl_nxt;
  logic [2:0] ev_nxt;

  logic        s1_adv;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic [7:0]  sil_inc;
  logic [7:0]  ind_cur;
  logic [5:0]  code;
  logic [3:0]  sel;
  lcfr_drive_t drive;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[3:2];

  // The first stage moves on when the result register is free or being emptied.
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (cfg_idx)
      REG_FULL_DUTY: prdata = {{(CFG_DW-10){1'b0}}, full_duty_r};
      REG_DIM_DUTY:  prdata = {{(CFG_DW-10){1'b0}}, dim_duty_r};
      REG_TIMEOUT:   prdata = {{(CFG_DW-8){1'b0}}, timeout_r};
      default:       prdata = '0;
    endcase
  end

  // The indicator byte is also the check byte when the frame is only four bytes long.
  assign ind_cur = (pos_r == 4'd3) ? s1_item_r.byte_value : ind_r;
  assign code = {ctrl_r[2], ctrl_r[3], ctrl_r[4], ctrl_r[5], ind_cur[5], ind_cur[6]};
  assign sel   = {code[2], code[3], code[4], code[5]};
  assign drive = drive_lookup(sel);
  assign sil_inc = silence_r + 8'd1;

  always_comb begin
    pos_nxt     = pos_r;
    ctrl_nxt    = ctrl_r;
    ind_nxt     = ind_r;
    silence_nxt = silence_r;
    high_nxt    = high_r;
    low_nxt     = low_r;
    posl_nxt    = posl_r;
    ev_nxt      = EV_NONE;
    if (s1_item_r.command) begin
      if (sil_inc >= timeout_r) begin
        silence_nxt = '0;
        high_nxt    = 1'b0;
        low_nxt     = full_duty_r;
        posl_nxt    = 1'b1;
        ev_nxt      = EV_TIMEOUT;
      end else begin
        silence_nxt = sil_inc;
      end
    end else if (pos_r >= POS_LIMIT) begin
      pos_nxt = '0;
    end else if (pos_r == 4'd0) begin
      pos_nxt = (s1_item_r.byte_value == HDR0) ? 4'd1 : 4'd0;
    end else if (pos_r == 4'd1) begin
      pos_nxt = (s1_item_r.byte_value == HDR1) ? 4'd2 : 4'd0;
    end else begin
      if (pos_r == 4'd2) begin
        ctrl_nxt = s1_item_r.byte_value;
      end
      if (pos_r == 4'd3) begin
        ind_nxt = s1_item_r.byte_value;
      end
      if (pos_r == POS_LAST) begin
        pos_nxt = '0;
        if (ctrl_r == UNLOCK_CTRL && s1_item_r.byte_value == UNLOCK_CHECK) begin
          high_nxt    = 1'b0;
          low_nxt     = '0;
          posl_nxt    = 1'b1;
          silence_nxt = '0;
          ev_nxt      = EV_UNLOCK;
        end else if (s1_item_r.byte_value != CHECK_ROM[code]) begin
          ev_nxt = EV_BADCHECK;
        end else begin
          silence_nxt = '0;
          high_nxt    = drive.high;
          case (drive.lb)
            LB_FULL: low_nxt = full_duty_r;
            LB_DIM:  low_nxt = dim_duty_r;
            default: low_nxt = '0;
          endcase
          if (drive.ps != PS_KEEP) begin
            posl_nxt = (drive.ps == PS_ON);
          end
          ev_nxt = EV_APPLIED;
        end
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_duty_r <= FULL_DUTY_RST;
      dim_duty_r  <= DIM_DUTY_RST;
      timeout_r   <= TIMEOUT_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      ctrl_r      <= '0;
      ind_r       <= '0;
      silence_r   <= '0;
      high_r      <= 1'b0;
      low_r       <= '0;
      posl_r      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_FULL_DUTY: full_duty_r <= pwdata[9:0];
          REG_DIM_DUTY:  dim_duty_r  <= pwdata[9:0];
          REG_TIMEOUT:   timeout_r   <= pwdata[7:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv && s1_valid_r) begin
        pos_r     <= pos_nxt;
        ctrl_r    <= ctrl_nxt;
        ind_r     <= ind_nxt;
        silence_r <= silence_nxt;
        high_r    <= high_nxt;
        low_r     <= low_nxt;
        posl_r    <= posl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= '{high_beam: high_nxt, low_beam_duty: low_nxt,
                      position_lamp: posl_nxt, event_res: ev_nxt};
    end
  end

`include "lamp_command_frame_receiver_assert.svh"

  `LCFR_ASSERT_IMP(a_pos_in_range, 1'b1, pos_r < POS_LIMIT, "frame position out of range")
  `LCFR_ASSERT_IMP(a_unlock_drive,
    out_valid_r && out_data_r.event_res == EV_UNLOCK,
    !out_data_r.high_beam && out_data_r.low_beam_duty == 10'd0 && out_data_r.position_lamp,
    "unlock result with wrong lamp drive")
  `LCFR_ASSERT_IMP(a_timeout_drive,
    out_valid_r && out_data_r.event_res == EV_TIMEOUT,
    !out_data_r.high_beam && out_data_r.position_lamp,
    "timeout result with wrong lamp drive")
  `LCFR_ASSERT_IMP(a_no_overrun, in_valid && in_ready,
    !(s1_valid_r && out_valid_r && !out_ready), "input taken while both stages are blocked")
  `LCFR_ASSERT_NEXT(a_silence_cleared,
    s1_adv && s1_valid_r && (ev_nxt == EV_APPLIED || ev_nxt == EV_UNLOCK || ev_nxt == EV_TIMEOUT),
    silence_r == 8'd0, "silence timer not restarted")

endmodule

`default_nettype wire
